// ===== hdl/pal_pkg.sv =====
// Shared types and codes of the packed array list unit.
`default_nettype none

package pal_pkg;

    localparam logic [2:0] KIND_APPEND = 3'd0;
    localparam logic [2:0] KIND_READ   = 3'd1;
    localparam logic [2:0] KIND_WRITE  = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_FIND   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_FIND  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/pal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/packed_array_list_unit.sv =====
// Top level of the packed array list unit: request sequencer around the entry RAM.
`default_nettype none

// Usage
//   A request beat is taken at a rising edge where start is high and busy is low.
//   i_kind selects append, read, write, remove or find; i_operand is the word for
//   append and find, the position for read, write and remove; i_new_value is the
//   word stored by write. Every request returns exactly one result beat, marked by
//   o_done for one cycle, with read data, found position, entry count and status.
// Sequencing
//   Append, write, bad positions, last-entry remove, empty-list find, unused kinds:
//   result the next cycle; busy stays low, so such requests can follow every cycle.
//   Read: the RAM registers the read data, then S_READ registers the result.
//   Remove at position p: S_SHIFT moves entries p+1 to count-1 down one place, one
//   entry moved per cycle through the single read and write ports of the RAM.
//   Find: S_FIND compares one entry per cycle from position 0 up to the first match.
//   Busy is high in S_READ, S_SHIFT and S_FIND, so no new request is taken there.
// Reset
//   Synchronous, active low; clears the count and the sequencer. The RAM needs
//   no clearing pass: only entries below the count are ever read.
// The receiver cannot stall: each result beat is presented for one cycle only.
module packed_array_list_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_kind,
    input  wire logic signed [31:0] i_operand,
    input  wire logic signed [31:0] i_new_value,
    output logic                    o_done,
    output logic signed [31:0]      o_read_data,
    output logic [3:0]              o_found_position,
    output logic [4:0]              o_entry_count,
    output logic [1:0]              o_status
);

    import pal_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_idx, n_idx;
    logic [31:0]    r_key, n_key;
    logic           r_done, n_done;
    logic [31:0]    r_out_rdata, n_out_rdata;
    logic [3:0]     r_out_fpos, n_out_fpos;
    logic [4:0]     r_out_count;
    logic [1:0]     r_out_status, n_out_status;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [31:0]    mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic [31:0]    mem_rdata;

    logic [31:0]    opnd_u;
    logic           pos_ok;
    logic [CW-1:0]  pos_c;
    logic [CW-1:0]  pos_inc;
    logic [CW-1:0]  idx_inc;
    logic [CW-1:0]  idx_dec;
    logic [31:0]    cnt_ext;
    logic [31:0]    idx_ext;

    pal_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign opnd_u  = $unsigned(i_operand);
    assign pos_ok  = !opnd_u[31] && (opnd_u < 32'(r_count));
    assign pos_c   = opnd_u[CW-1:0];
    assign pos_inc = pos_c + 1'b1;
    assign idx_inc = r_idx + 1'b1;
    assign idx_dec = r_idx - 1'b1;
    assign cnt_ext = 32'(n_count);
    assign idx_ext = 32'(r_idx);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_key        = r_key;
        n_done       = 1'b0;
        n_out_rdata  = '0;
        n_out_fpos   = '0;
        n_out_status = ST_OK;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_kind)
                        KIND_APPEND: begin
                            n_done = 1'b1;
                            if (r_count < CW'(DEPTH)) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = opnd_u;
                                n_count   = r_count + 1'b1;
                            end else begin
                                n_out_status = ST_FULL;
                            end
                        end
                        KIND_READ: begin
                            if (pos_ok) begin
                                mem_raddr = opnd_u[AW-1:0];
                                n_state   = S_READ;
                            end else begin
                                n_done       = 1'b1;
                                n_out_status = ST_RANGE;
                            end
                        end
                        KIND_WRITE: begin
                            n_done = 1'b1;
                            if (pos_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = opnd_u[AW-1:0];
                                mem_wdata = $unsigned(i_new_value);
                            end else begin
                                n_out_status = ST_RANGE;
                            end
                        end
                        KIND_REMOVE: begin
                            if (!pos_ok) begin
                                n_done       = 1'b1;
                                n_out_status = ST_RANGE;
                            end else if (pos_inc < r_count) begin
                                mem_raddr = pos_inc[AW-1:0];
                                n_idx     = pos_inc;
                                n_state   = S_SHIFT;
                            end else begin
                                n_done  = 1'b1;
                                n_count = r_count - 1'b1;
                            end
                        end
                        KIND_FIND: begin
                            if (r_count == '0) begin
                                n_done       = 1'b1;
                                n_out_status = ST_NOTFOUND;
                            end else begin
                                mem_raddr = '0;
                                n_idx     = '0;
                                n_key     = opnd_u;
                                n_state   = S_FIND;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_done      = 1'b1;
                n_out_rdata = mem_rdata;
                n_state     = S_IDLE;
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = idx_dec[AW-1:0];
                mem_wdata = mem_rdata;
                if (idx_inc < r_count) begin
                    mem_raddr = idx_inc[AW-1:0];
                    n_idx     = idx_inc;
                end else begin
                    n_done  = 1'b1;
                    n_count = r_count - 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                if (mem_rdata == r_key) begin
                    n_done     = 1'b1;
                    n_out_fpos = idx_ext[3:0];
                    n_state    = S_IDLE;
                end else if (idx_inc < r_count) begin
                    mem_raddr = idx_inc[AW-1:0];
                    n_idx     = idx_inc;
                end else begin
                    n_done       = 1'b1;
                    n_out_status = ST_NOTFOUND;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_key <= n_key;
        if (n_done) begin
            r_out_rdata  <= n_out_rdata;
            r_out_fpos   <= n_out_fpos;
            r_out_count  <= cnt_ext[4:0];
            r_out_status <= n_out_status;
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_read_data      = $signed(r_out_rdata);
    assign o_found_position = r_out_fpos;
    assign o_entry_count    = r_out_count;
    assign o_status         = r_out_status;

endmodule

`default_nettype wire
